// File: rtl/lfu_pkg.sv
package lfu_pkg;

  localparam int PAGE_BITS  = 16;
  localparam int CFG_BITS   = 4;
  localparam int SLOT_BITS  = 3;
  localparam int FAULT_BITS = 32;

  typedef logic [PAGE_BITS-1:0] page_t;

  typedef struct packed {
    page_t page_number;
    logic  end_of_sequence;
  } in_t;

  typedef struct packed {
    logic                  hit;
    logic [SLOT_BITS-1:0]  frame_slot;
    logic                  evicted_valid;
    page_t                 evicted_page;
    logic [FAULT_BITS-1:0] fault_total;
  } out_t;

  typedef enum logic [1:0] {
    CMD_NONE,
    CMD_INC,
    CMD_FILL,
    CMD_CLEAR
  } cmd_t;

  typedef struct packed {
    cmd_t  cmd;
    page_t page;
  } wr_t;

  typedef struct packed {
    page_t page;
    logic  found;
    logic  min_set;
    logic  min_valid;
    page_t min_page;
  } probe_t;

endpackage

// File: rtl/lfu_cell.sv
module lfu_cell
  import lfu_pkg::*;
#(
  parameter int IDX        = 0,
  parameter int IDX_BITS   = 3,
  parameter int COUNT_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  active,
  input  probe_t                probe_in,
  input  logic [IDX_BITS-1:0]   hit_slot_in,
  input  logic [IDX_BITS-1:0]   min_slot_in,
  input  logic [COUNT_BITS-1:0] min_count_in,
  output probe_t                probe_out,
  output logic [IDX_BITS-1:0]   hit_slot_out,
  output logic [IDX_BITS-1:0]   min_slot_out,
  output logic [COUNT_BITS-1:0] min_count_out,
  input  wr_t                   wr,
  input  logic [IDX_BITS-1:0]   wr_slot
);

  localparam logic [IDX_BITS-1:0]   MY_SLOT = IDX_BITS'(IDX);
  localparam logic [COUNT_BITS-1:0] ONE     = {{(COUNT_BITS-1){1'b0}}, 1'b1};

  page_t                 page;
  logic                  valid;
  logic [COUNT_BITS-1:0] count;

  logic match;
  logic take;

  probe_t                probe_next;
  logic [IDX_BITS-1:0]   hit_slot_next;
  logic [IDX_BITS-1:0]   min_slot_next;
  logic [COUNT_BITS-1:0] min_count_next;

  assign match = active && valid && (page == probe_in.page) && !probe_in.found;
  assign take  = active && (!probe_in.min_set || (count < min_count_in));

  always_comb begin
    probe_next     = probe_in;
    hit_slot_next  = hit_slot_in;
    min_slot_next  = min_slot_in;
    min_count_next = min_count_in;
    if (match) begin
      probe_next.found = 1'b1;
      hit_slot_next    = MY_SLOT;
    end
    if (take) begin
      probe_next.min_set   = 1'b1;
      probe_next.min_valid = valid;
      probe_next.min_page  = page;
      min_slot_next        = MY_SLOT;
      min_count_next       = count;
    end
  end

  always_ff @(posedge clk) begin
    probe_out     <= probe_next;
    hit_slot_out  <= hit_slot_next;
    min_slot_out  <= min_slot_next;
    min_count_out <= min_count_next;
  end

  always_ff @(posedge clk) begin
    if (rst || wr.cmd == CMD_CLEAR) begin
      page  <= '0;
      valid <= 1'b0;
      count <= '0;
    end else if (wr_slot == MY_SLOT) begin
      unique case (wr.cmd)
        CMD_INC: begin
          if (count != '1) begin
            count <= count + ONE;
          end
        end
        CMD_FILL: begin
          page  <= wr.page;
          valid <= 1'b1;
          count <= ONE;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// File: rtl/lfu_page_replacement.sv
// Channel  Direction  Signals
// in       input      in_valid, in_ready, in_data (in_t)
// out      output     out_valid, out_ready, out_data (out_t)
// cfg      input      cfg_wr_en, cfg_wr_data (frames_in_use)
//
// In a transaction the probe walks the chain of frame cells one cell a cycle,
// then the write state writes back and loads the result.
// A new transaction is taken once the previous write-back is done.
// A result stalled at the output holds the write-back until it is taken.
// Synchronous reset clears all frames, the fault total and frames_in_use to 8.
module lfu_page_replacement
  import lfu_pkg::*;
#(
  parameter int FRAMES     = 8,
  parameter int COUNT_BITS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  in_t                 in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output out_t                out_data,
  input  logic                cfg_wr_en,
  input  logic [CFG_BITS-1:0] cfg_wr_data
);

  localparam int IDX_BITS = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam logic [IDX_BITS-1:0] LAST_STEP = IDX_BITS'(FRAMES - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_WRITE
  } state_t;

  state_t                 state;
  logic [IDX_BITS-1:0]    step;
  in_t                    req;
  logic [CFG_BITS-1:0]    frames_in_use;
  logic [FAULT_BITS-1:0]  fault;
  logic [FAULT_BITS-1:0]  fault_next;

  probe_t                         probe     [FRAMES+1];
  logic [FRAMES:0][IDX_BITS-1:0]   hit_slot;
  logic [FRAMES:0][IDX_BITS-1:0]   min_slot;
  logic [FRAMES:0][COUNT_BITS-1:0] min_count;
  logic [FRAMES-1:0]               active;

  wr_t                 wr;
  logic [IDX_BITS-1:0] wr_slot;
  logic                commit;
  probe_t              res;
  logic [IDX_BITS-1:0] res_slot;
  logic                ev_valid;

  assign in_ready = (state == ST_IDLE);

  assign probe[0] = '{page: req.page_number, found: 1'b0, min_set: 1'b0,
                      min_valid: 1'b0, min_page: '0};
  assign hit_slot[0]        = '0;
  assign min_slot[0]        = '0;
  assign min_count[0]       = '0;

  for (genvar i = 0; i < FRAMES; i++) begin : g_cell
    assign active[i] = (i == 0) || (32'(frames_in_use) > 32'(i));

    lfu_cell #(
      .IDX        (i),
      .IDX_BITS   (IDX_BITS),
      .COUNT_BITS (COUNT_BITS)
    ) u_cell (
      .clk           (clk),
      .rst           (rst),
      .active        (active[i]),
      .probe_in      (probe[i]),
      .hit_slot_in   (hit_slot[i]),
      .min_slot_in   (min_slot[i]),
      .min_count_in  (min_count[i]),
      .probe_out     (probe[i+1]),
      .hit_slot_out  (hit_slot[i+1]),
      .min_slot_out  (min_slot[i+1]),
      .min_count_out (min_count[i+1]),
      .wr            (wr),
      .wr_slot       (wr_slot)
    );
  end

  assign res      = probe[FRAMES];
  assign res_slot = res.found ? hit_slot[FRAMES] : min_slot[FRAMES];
  assign ev_valid = !res.found && res.min_valid;
  assign commit   = (state == ST_WRITE) && (!out_valid || out_ready);

  assign fault_next = (!res.found && fault != '1) ? fault + FAULT_BITS'(1) : fault;

  always_comb begin
    wr.page = req.page_number;
    wr.cmd  = CMD_NONE;
    wr_slot = res_slot;
    if (commit) begin
      if (req.end_of_sequence) begin
        wr.cmd = CMD_CLEAR;
      end else if (res.found) begin
        wr.cmd = CMD_INC;
      end else begin
        wr.cmd = CMD_FILL;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      step          <= '0;
      out_valid     <= 1'b0;
      fault         <= '0;
      frames_in_use <= CFG_BITS'(8);
    end else begin
      if (cfg_wr_en) begin
        frames_in_use <= cfg_wr_data;
      end
      if (out_ready && !commit) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            req   <= in_data;
            step  <= '0;
            state <= ST_SEARCH;
          end
        end
        ST_SEARCH: begin
          if (step == LAST_STEP) begin
            state <= ST_WRITE;
          end else begin
            step <= step + IDX_BITS'(1);
          end
        end
        ST_WRITE: begin
          if (commit) begin
            out_valid              <= 1'b1;
            out_data.hit           <= res.found;
            out_data.frame_slot    <= SLOT_BITS'(res_slot);
            out_data.evicted_valid <= ev_valid;
            out_data.evicted_page  <= ev_valid ? res.min_page : '0;
            out_data.fault_total   <= fault_next;
            fault                  <= req.end_of_sequence ? '0 : fault_next;
            state                  <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
